FILE: src/swfd_pkg.sv
`timescale 1ns / 1ps
package swfd_pkg;

    // frame kinds as held in the configuration register
    localparam logic FRAME_MEAS    = 1'b0;
    localparam logic FRAME_VERSION = 1'b1;

    // frame lengths in bytes
    localparam logic [2:0] MEAS_LEN    = 3'd6;
    localparam logic [2:0] VERSION_LEN = 3'd3;

    // byte positions within a frame
    localparam logic [2:0] POS_MSB0 = 3'd0;
    localparam logic [2:0] POS_LSB0 = 3'd1;
    localparam logic [2:0] POS_CRC0 = 3'd2;
    localparam logic [2:0] POS_MSB1 = 3'd3;
    localparam logic [2:0] POS_LSB1 = 3'd4;

    // crc-8 over the two word bytes
    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    // scaling constants, full scale is 2^16 - 1
    localparam logic [14:0] TEMP_SCALE  = 15'd17500;
    localparam logic [13:0] HUM_SCALE   = 14'd10000;
    localparam logic [15:0] TEMP_OFFSET = 16'd4500;
    localparam logic [15:0] BAD_VERSION = 16'hFFFF;

    // decoded frame handed from front to back
    typedef struct packed {
        logic        kind;
        logic [15:0] word0;
        logic        ok0;
        logic [15:0] word1;
        logic        ok1;
    } job_t;

    // one byte through the crc register, msb first
    function automatic logic [7:0] crc8_step(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] c;
        c = crc_in ^ data;
        for (int i = 0; i < 8; i++)
        begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

FILE: src/swfd_in_if.sv
`timescale 1ns / 1ps
interface swfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_start;

    modport source (output valid, output data_byte, output frame_start, input ready);
    modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

FILE: src/swfd_out_if.sv
`timescale 1ns / 1ps
interface swfd_out_if;
    logic               valid;
    logic               ready;
    logic signed [14:0] temperature_centi;
    logic               temperature_ok;
    logic        [13:0] humidity_centi;
    logic               humidity_ok;
    logic        [15:0] version_word;

    modport source (output valid, output temperature_centi, output temperature_ok,
                    output humidity_centi, output humidity_ok, output version_word,
                    input ready);
    modport sink   (input valid, input temperature_centi, input temperature_ok,
                    input humidity_centi, input humidity_ok, input version_word,
                    output ready);
endinterface

FILE: src/swfd_cfg_if.sv
`timescale 1ns / 1ps
interface swfd_cfg_if;
    logic valid;
    logic ready;
    logic frame_kind;

    modport source (output valid, output frame_kind, input ready);
    modport sink   (input valid, input frame_kind, output ready);
endinterface

FILE: src/swfd_front.sv
`timescale 1ns / 1ps
module swfd_front (
    input  logic          clk,
    input  logic          rst_n,
    swfd_cfg_if.sink      cfg,
    swfd_in_if.sink       sample,
    input  logic          full,
    output logic          push,
    output swfd_pkg::job_t push_job
);

    logic        frame_kind_reg;
    logic [2:0]  pos_reg, pos_next;
    logic [15:0] word_hold_reg, word_hold_next;
    logic [7:0]  crc_reg, crc_next;
    logic [15:0] first_raw_reg, first_raw_next;
    logic        first_good_reg, first_good_next;
    logic [2:0]  frame_len;
    logic [2:0]  pos_eff;
    logic        accept;
    logic        crc_match;
    logic        push_cand;

    // configuration write, always accepted
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_kind_reg <= swfd_pkg::FRAME_MEAS;
        end
        else if (cfg.valid)
        begin
            frame_kind_reg <= cfg.frame_kind;
        end
    end

    // take a byte whenever the queue has room
    assign sample.ready = !full;
    assign accept       = sample.valid && !full;

    // resync on frame start or on a position beyond this frame length
    assign frame_len = (frame_kind_reg == swfd_pkg::FRAME_VERSION) ? swfd_pkg::VERSION_LEN
                                                                    : swfd_pkg::MEAS_LEN;
    assign pos_eff   = (sample.frame_start || pos_reg >= frame_len) ? swfd_pkg::POS_MSB0
                                                                     : pos_reg;
    assign crc_match = (crc_reg == sample.data_byte);

    // position decoder
    always_comb
    begin
        pos_next        = pos_reg;
        word_hold_next  = word_hold_reg;
        crc_next        = crc_reg;
        first_raw_next  = first_raw_reg;
        first_good_next = first_good_reg;
        push_cand       = 1'b0;
        push_job        = '0;
        unique case (pos_eff) inside
            swfd_pkg::POS_MSB0, swfd_pkg::POS_MSB1:
            begin
                word_hold_next = {sample.data_byte, 8'h00};
                crc_next       = swfd_pkg::crc8_step(swfd_pkg::CRC_INIT, sample.data_byte);
                pos_next       = pos_eff + 3'd1;
            end
            swfd_pkg::POS_LSB0, swfd_pkg::POS_LSB1:
            begin
                word_hold_next = {word_hold_reg[15:8], sample.data_byte};
                crc_next       = swfd_pkg::crc8_step(crc_reg, sample.data_byte);
                pos_next       = pos_eff + 3'd1;
            end
            swfd_pkg::POS_CRC0:
            begin
                if (frame_kind_reg == swfd_pkg::FRAME_VERSION)
                begin
                    push_cand      = 1'b1;
                    push_job.kind  = swfd_pkg::FRAME_VERSION;
                    push_job.word0 = word_hold_reg;
                    push_job.ok0   = crc_match;
                    pos_next       = swfd_pkg::POS_MSB0;
                end
                else
                begin
                    first_raw_next  = word_hold_reg;
                    first_good_next = crc_match;
                    pos_next        = swfd_pkg::POS_MSB1;
                end
            end
            default:
            begin
                // second check byte closes a measurement frame
                push_cand      = 1'b1;
                push_job.kind  = swfd_pkg::FRAME_MEAS;
                push_job.word0 = first_raw_reg;
                push_job.ok0   = first_good_reg;
                push_job.word1 = word_hold_reg;
                push_job.ok1   = crc_match;
                pos_next       = swfd_pkg::POS_MSB0;
            end
        endcase
    end

    assign push = accept && push_cand;

    // frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= swfd_pkg::POS_MSB0;
            word_hold_reg  <= '0;
            crc_reg        <= swfd_pkg::CRC_INIT;
            first_raw_reg  <= '0;
            first_good_reg <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg        <= pos_next;
            word_hold_reg  <= word_hold_next;
            crc_reg        <= crc_next;
            first_raw_reg  <= first_raw_next;
            first_good_reg <= first_good_next;
        end
    end

endmodule

FILE: src/swfd_queue.sv
`timescale 1ns / 1ps
module swfd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  swfd_pkg::job_t push_job,
    input  logic           pop,
    output swfd_pkg::job_t head_job,
    output logic           full,
    output logic           empty
);

    swfd_pkg::job_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign head_job = entry_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

FILE: src/swfd_back.sv
`timescale 1ns / 1ps
module swfd_back (
    input  logic           clk,
    input  logic           rst_n,
    input  swfd_pkg::job_t head_job,
    input  logic           empty,
    output logic           pop,
    swfd_out_if.source     result
);

    logic        s1_valid_reg;
    logic        s1_kind_reg;
    logic        s1_ok0_reg;
    logic        s1_ok1_reg;
    logic [15:0] s1_word0_reg;
    logic [30:0] s1_tprod_reg;
    logic [29:0] s1_hprod_reg;

    logic               out_valid_reg;
    logic signed [14:0] temp_reg, temp_next;
    logic               temp_ok_reg, temp_ok_next;
    logic        [13:0] hum_reg, hum_next;
    logic               hum_ok_reg, hum_ok_next;
    logic        [15:0] ver_reg, ver_next;

    logic        out_free;
    logic        s1_move;
    logic [31:0] tsum;
    logic [31:0] hsum;
    logic [15:0] tquot;
    logic [15:0] hquot;
    logic [15:0] temp_wide;

    // pipeline advance
    assign out_free = !out_valid_reg || result.ready;
    assign s1_move  = s1_valid_reg && out_free;
    assign pop      = !empty && (!s1_valid_reg || s1_move);

    // stage 1: constant scale multiplies
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!s1_valid_reg || s1_move)
        begin
            s1_valid_reg <= pop;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_kind_reg  <= head_job.kind;
            s1_ok0_reg   <= head_job.ok0;
            s1_ok1_reg   <= head_job.ok1;
            s1_word0_reg <= head_job.word0;
            s1_tprod_reg <= 31'(head_job.word0) * 31'(swfd_pkg::TEMP_SCALE);
            s1_hprod_reg <= 30'(head_job.word1) * 30'(swfd_pkg::HUM_SCALE);
        end
    end

    // stage 2: floor division by 65535 as (x + (x >> 16) + 1) >> 16
    assign tsum      = 32'(s1_tprod_reg) + 32'(s1_tprod_reg[30:16]) + 32'd1;
    assign hsum      = 32'(s1_hprod_reg) + 32'(s1_hprod_reg[29:16]) + 32'd1;
    assign tquot     = tsum[31:16];
    assign hquot     = hsum[31:16];
    assign temp_wide = tquot - swfd_pkg::TEMP_OFFSET;

    // result fields, unused ones forced to zero
    always_comb
    begin
        temp_next    = '0;
        temp_ok_next = 1'b0;
        hum_next     = '0;
        hum_ok_next  = 1'b0;
        ver_next     = '0;
        if (s1_kind_reg == swfd_pkg::FRAME_VERSION)
        begin
            ver_next = s1_ok0_reg ? s1_word0_reg : swfd_pkg::BAD_VERSION;
        end
        else
        begin
            if (s1_ok0_reg)
            begin
                temp_next    = $signed(temp_wide[14:0]);
                temp_ok_next = 1'b1;
            end
            if (s1_ok1_reg)
            begin
                hum_next    = hquot[13:0];
                hum_ok_next = 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            temp_reg    <= temp_next;
            temp_ok_reg <= temp_ok_next;
            hum_reg     <= hum_next;
            hum_ok_reg  <= hum_ok_next;
            ver_reg     <= ver_next;
        end
    end

    assign result.valid             = out_valid_reg;
    assign result.temperature_centi = temp_reg;
    assign result.temperature_ok    = temp_ok_reg;
    assign result.humidity_centi    = hum_reg;
    assign result.humidity_ok       = hum_ok_reg;
    assign result.version_word      = ver_reg;

endmodule

FILE: src/sensor_word_frame_decoder_top.sv
`timescale 1ns / 1ps
// sensor word frame decoder
// sample: one response byte per transfer, frame_start marks byte 0 of a frame.
// result: one transfer per completed frame; measurement frames (six bytes)
//   give scaled temperature and humidity with crc ok flags, version frames
//   (three bytes) give the word or 0xffff on a crc mismatch.
// cfg: single-bit frame_kind write, always ready; write it only while idle.
// throughput: one byte per cycle; sample.ready drops only when the two-entry
//   queue between byte decoder and scaling pipeline is full.
// path: the job for the last byte of a frame is written into the queue, then
//   read into the multiply stage, then divided by 65535 into the output register.
// stall: while result.ready is low the result holds, the pipeline and queue
//   fill, and bytes keep being taken until the queue is full.
// reset: frame position returns to byte 0, frame_kind to measurement mode,
//   queue and pipeline empty. no clearing pass.
module sensor_word_frame_decoder_top (
    input  logic        clk,
    input  logic        rst_n,
    swfd_cfg_if.sink    cfg,
    swfd_in_if.sink     sample,
    swfd_out_if.source  result
);

    logic           push;
    logic           pop;
    logic           full;
    logic           empty;
    swfd_pkg::job_t push_job;
    swfd_pkg::job_t head_job;

    swfd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .sample   (sample),
        .full     (full),
        .push     (push),
        .push_job (push_job)
    );

    swfd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .full     (full),
        .empty    (empty)
    );

    swfd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_job (head_job),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

    // no push into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("queue overflow");

    // no pop from an empty queue
    assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
        else $error("queue underflow");

    // nonzero version word means measurement fields are cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.version_word != 16'd0) |->
        (!result.temperature_ok && !result.humidity_ok &&
         result.temperature_centi == 15'sd0 && result.humidity_centi == 14'd0))
        else $error("version result carries measurement data");

    // scaled values stay in range, invalid ones are zero
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |->
        ((result.temperature_ok ? (result.temperature_centi >= -15'sd4500 &&
                                   result.temperature_centi <= 15'sd13000)
                                : (result.temperature_centi == 15'sd0)) &&
         (result.humidity_ok ? (result.humidity_centi <= 14'd10000)
                             : (result.humidity_centi == 14'd0))))
        else $error("scaled value out of range");

endmodule
